@@ sv/iul_pkg.sv @@
package iul_pkg;
  localparam int unsigned MaxSegments = 256;
  localparam int unsigned Depth = 2 * MaxSegments;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW = AddrW + 1;
  localparam int unsigned CoordW = 32;
  localparam int unsigned OpenW = CntW;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusReversed = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StSortRd,
    StSortCmp,
    StSortShift,
    StSortPlace,
    StSweepRd,
    StSweepAcc,
    StDone
  } state_e;

  // one endpoint entry: biased coordinate plus start flag
  typedef struct packed {
    logic [CoordW-1:0] coord;
    logic              is_start;
  } entry_t;

  // memory port request from the controller
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  function automatic logic [CoordW:0] sort_key(entry_t e);
    return {e.coord, ~e.is_start};
  endfunction
endpackage

@@ sv/iul_ram.sv @@
module iul_ram (
  input  logic               clk_i,
  input  iul_pkg::mem_req_t  req_i,
  output iul_pkg::entry_t    rdata_o
);
  iul_pkg::entry_t mem_q [iul_pkg::Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end
endmodule

@@ sv/iul_ctrl.sv @@
module iul_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [31:0]           left_coord_i,
  input  logic signed [31:0]           right_coord_i,
  input  logic                         is_last_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [31:0]                  covered_length_o,
  output logic [1:0]                   status_o,
  output iul_pkg::mem_req_t            req_o,
  input  iul_pkg::entry_t              rdata_i
);
  localparam int unsigned AW = iul_pkg::AddrW;
  localparam int unsigned CW = iul_pkg::CntW;

  iul_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;        // stored endpoints
  logic [1:0]    err_q, err_d;
  logic [CW-1:0] i_q, i_d;            // outer index
  logic [CW-1:0] j_q, j_d;            // insertion index
  iul_pkg::entry_t key_q, key_d;      // element being inserted / previous endpoint
  logic [31:0]   total_q, total_d;
  logic [iul_pkg::OpenW-1:0] open_q, open_d;
  logic          wr2_q, wr2_d;        // second endpoint write pending
  logic [31:0]   rpend_q, rpend_d;
  logic [31:0]   res_len_q, res_len_d;
  logic [1:0]    res_st_q, res_st_d;

  logic accept;
  logic [31:0] lb, rb;
  assign accept = start_i && !busy_o;
  assign lb = left_coord_i ^ 32'h8000_0000;
  assign rb = right_coord_i ^ 32'h8000_0000;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iul_pkg::StIdle: begin
        if (accept && is_last_i) begin
          state_d = iul_pkg::StSortRd;
        end
      end
      iul_pkg::StSortRd: begin
        if (wr2_q) state_d = iul_pkg::StSortRd;
        else if (err_q != iul_pkg::StatusOk || i_q >= cnt_q) state_d = iul_pkg::StSweepRd;
        else state_d = iul_pkg::StSortCmp;
      end
      iul_pkg::StSortCmp: state_d = iul_pkg::StSortShift;
      iul_pkg::StSortShift: begin
        if (j_q != '0 && iul_pkg::sort_key(rdata_i) > iul_pkg::sort_key(key_q))
          state_d = iul_pkg::StSortShift;
        else state_d = iul_pkg::StSortPlace;
      end
      iul_pkg::StSortPlace: state_d = iul_pkg::StSortRd;
      iul_pkg::StSweepRd: begin
        if (err_q != iul_pkg::StatusOk || i_q >= cnt_q) state_d = iul_pkg::StDone;
        else state_d = iul_pkg::StSweepAcc;
      end
      iul_pkg::StSweepAcc: state_d = iul_pkg::StSweepRd;
      iul_pkg::StDone: state_d = iul_pkg::StIdle;
      default: state_d = iul_pkg::StIdle;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    cnt_d = cnt_q; err_d = err_q; i_d = i_q; j_d = j_q; key_d = key_q;
    total_d = total_q; open_d = open_q; wr2_d = 1'b0; rpend_d = rpend_q;
    res_len_d = res_len_q; res_st_d = res_st_q;
    req_o = '0;
    busy_o = (state_q != iul_pkg::StIdle) || wr2_q;
    unique case (state_q)
      iul_pkg::StIdle: begin
        if (wr2_q) begin
          req_o.we = 1'b1;
          req_o.waddr = cnt_q[AW-1:0];
          req_o.wdata = '{coord: rpend_q, is_start: 1'b0};
          cnt_d = cnt_q + CW'(1);
        end else if (accept) begin
          if (rb < lb) begin
            if (err_q == iul_pkg::StatusOk) err_d = iul_pkg::StatusReversed;
          end else if (CW'(cnt_q + CW'(2)) > CW'(iul_pkg::Depth)) begin
            if (err_q == iul_pkg::StatusOk) err_d = iul_pkg::StatusFull;
          end else begin
            req_o.we = 1'b1;
            req_o.waddr = cnt_q[AW-1:0];
            req_o.wdata = '{coord: lb, is_start: 1'b1};
            cnt_d = cnt_q + CW'(1);
            wr2_d = 1'b1;
            rpend_d = rb;
          end
          i_d = CW'(1);
        end
      end
      iul_pkg::StSortRd: begin
        if (wr2_q) begin
          req_o.we = 1'b1;
          req_o.waddr = cnt_q[AW-1:0];
          req_o.wdata = '{coord: rpend_q, is_start: 1'b0};
          cnt_d = cnt_q + CW'(1);
        end else if (err_q != iul_pkg::StatusOk || i_q >= cnt_q) begin
          i_d = '0; total_d = '0; open_d = '0;
        end else begin
          req_o.raddr = i_q[AW-1:0];
          j_d = i_q;
        end
      end
      iul_pkg::StSortCmp: begin
        key_d = rdata_i;
        req_o.raddr = AW'(j_q - CW'(1));
      end
      iul_pkg::StSortShift: begin
        if (j_q != '0 && iul_pkg::sort_key(rdata_i) > iul_pkg::sort_key(key_q)) begin
          req_o.we = 1'b1;
          req_o.waddr = j_q[AW-1:0];
          req_o.wdata = rdata_i;
          j_d = j_q - CW'(1);
          // the read targets j-2; no overlap with the write at j
          req_o.raddr = AW'(j_q - CW'(2));
        end
      end
      iul_pkg::StSortPlace: begin
        req_o.we = 1'b1;
        req_o.waddr = j_q[AW-1:0];
        req_o.wdata = key_q;
        i_d = i_q + CW'(1);
      end
      iul_pkg::StSweepRd: begin
        if (err_q != iul_pkg::StatusOk || i_q >= cnt_q) begin
          res_len_d = (err_q == iul_pkg::StatusOk) ? total_q : 32'd0;
          res_st_d = err_q;
        end else begin
          req_o.raddr = i_q[AW-1:0];
        end
      end
      iul_pkg::StSweepAcc: begin
        if (i_q != '0 && open_q != '0) total_d = total_q + (rdata_i.coord - key_q.coord);
        if (rdata_i.is_start) open_d = open_q + 1'b1;
        else if (open_q != '0) open_d = open_q - 1'b1;
        key_d = rdata_i;
        i_d = i_q + CW'(1);
      end
      iul_pkg::StDone: begin
        cnt_d = '0; err_d = iul_pkg::StatusOk;
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == iul_pkg::StDone);
  assign covered_length_o = res_len_q;
  assign status_o = res_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iul_pkg::StIdle;
      cnt_q <= '0; err_q <= iul_pkg::StatusOk; wr2_q <= 1'b0;
      i_q <= '0; open_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; err_q <= err_d; wr2_q <= wr2_d;
      i_q <= i_d; open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; key_q <= key_d; total_q <= total_d; rpend_q <= rpend_d;
    res_len_q <= res_len_d; res_st_q <= res_st_d;
  end

  a_cnt_even_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iul_pkg::StIdle && !wr2_q) |-> !cnt_q[0]) else $error("odd endpoint count");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(iul_pkg::Depth)) else $error("endpoint count overflow");
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (cnt_q == '0 && err_q == iul_pkg::StatusOk)) else $error("set not cleared");
  a_err_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != iul_pkg::StatusOk) |-> covered_length_o == '0)
    else $error("length on error");
endmodule

@@ sv/interval_union_length_core.sv @@
// interval_union_length_core: covered length of the union of closed segments.
// Input: pulse start_i while busy_o is low with one segment on left_coord_i /
// right_coord_i (signed); is_last_i closes the set. Each accepted, error-free
// segment stores two endpoints in one 512-entry RAM (one RAM write port,
// one endpoint per cycle).
// After the last segment the endpoints are insertion-sorted in place in the
// RAM (read, compare, shift, place), then swept once.
// The result appears on covered_length_o / status_o for one cycle with
// done_o high; the receiver cannot stall, so it must take it then.
// Reversed segments (status 1) or overflow past 256 segments (status 2)
// skip sort and sweep; the first error of a set is reported, length 0.
// Reset clears the count and error status; RAM contents need no clearing.
module interval_union_length_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] left_coord_i,
  input  logic signed [31:0] right_coord_i,
  input  logic               is_last_i,
  output logic               done_o,
  output logic [31:0]        covered_length_o,
  output logic [1:0]         status_o
);
  iul_pkg::mem_req_t req;
  iul_pkg::entry_t   rdata;

  // sequencer: load, sort and sweep over the shared endpoint memory
  iul_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .left_coord_i, .right_coord_i, .is_last_i,
    .busy_o, .done_o, .covered_length_o, .status_o,
    .req_o(req), .rdata_i(rdata)
  );

  // endpoint store, registered read
  iul_ram u_ram (
    .clk_i, .req_i(req), .rdata_o(rdata)
  );
endmodule
